FILE: sv/tlb_lookup_with_lru_counters_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the translation buffer
// Shorthand for clocked, reset-qualified assertions.
// ---------------------------------------------------------------------------
`ifndef TLB_LOOKUP_WITH_LRU_COUNTERS_ASSERT_SVH
`define TLB_LOOKUP_WITH_LRU_COUNTERS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLBL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlbl: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TLBL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlbl: next-cycle check failed");

`endif

FILE: sv/tlbl_pkg.sv
// ---------------------------------------------------------------------------
// tlbl_pkg
// Item types, field widths and codes shared by the translation buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package tlbl_pkg;

    localparam int VA_W    = 28;
    localparam int TAG_LSB = 9;
    localparam int TAG_W   = 19;
    localparam int FRAME_W = 19;
    localparam int AGE_W   = 2;

    localparam logic [AGE_W-1:0] AGE_MAX  = 2'd3;
    localparam logic [AGE_W-1:0] AGE_ZERO = 2'd0;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    typedef struct packed {
        logic               func;
        logic [VA_W-1:0]    virtual_address;
        logic [FRAME_W-1:0] frame_address;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] found_address;
    } rsp_t;

    // Segment and page bits of a virtual address.
    function automatic logic [TAG_W-1:0] get_tag(input logic [VA_W-1:0] va);
        return va[TAG_LSB +: TAG_W];
    endfunction

endpackage

`default_nettype wire

FILE: sv/tlbl_entries.sv
// ---------------------------------------------------------------------------
// tlbl_entries
// Entry store with parallel tag compare, victim choice and age update.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tlb_lookup_with_lru_counters_assert.svh"

module tlbl_entries #(
    parameter int NUM_ENTRIES = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          go,
    input  wire tlbl_pkg::req_t req,
    output tlbl_pkg::rsp_t     rsp
);

    logic [NUM_ENTRIES-1:0]            valid_reg;
    logic [NUM_ENTRIES-1:0]            valid_next;
    logic [tlbl_pkg::AGE_W-1:0]        age_reg   [NUM_ENTRIES];
    logic [tlbl_pkg::AGE_W-1:0]        age_next  [NUM_ENTRIES];
    logic [tlbl_pkg::TAG_W-1:0]        tag_reg   [NUM_ENTRIES];
    logic [tlbl_pkg::FRAME_W-1:0]      frame_reg [NUM_ENTRIES];

    logic [tlbl_pkg::TAG_W-1:0]        tag_in;
    logic [NUM_ENTRIES-1:0]            match;
    logic [NUM_ENTRIES-1:0]            hit_oh;
    logic                              any_hit;
    logic [tlbl_pkg::FRAME_W-1:0]      hit_frame;
    logic [tlbl_pkg::AGE_W-1:0]        hit_age;
    logic [NUM_ENTRIES-1:0]            age0_vec;
    logic [NUM_ENTRIES-1:0]            age1_vec;
    logic [NUM_ENTRIES-1:0]            age2_vec;
    logic [NUM_ENTRIES-1:0]            age_nz_vec;
    logic [NUM_ENTRIES-1:0]            age_max_vec;
    logic [NUM_ENTRIES-1:0]            min_oh;
    logic [NUM_ENTRIES-1:0]            ins_oh;
    logic [NUM_ENTRIES-1:0]            wr_en;
    logic                              is_insert;

    // Isolate the lowest set bit.
    function automatic logic [NUM_ENTRIES-1:0] lowest_one(input logic [NUM_ENTRIES-1:0] v);
        return v & (~v + NUM_ENTRIES'(1));
    endfunction

    assign tag_in    = tlbl_pkg::get_tag(req.virtual_address);
    assign is_insert = (req.func == tlbl_pkg::FUNC_INSERT);

    always_comb
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            match[i]       = valid_reg[i] && (tag_reg[i] == tag_in);
            age0_vec[i]    = (age_reg[i] == tlbl_pkg::AGE_ZERO);
            age1_vec[i]    = (age_reg[i] == 2'd1);
            age2_vec[i]    = (age_reg[i] == 2'd2);
            age_nz_vec[i]  = (age_reg[i] != tlbl_pkg::AGE_ZERO);
            age_max_vec[i] = (age_reg[i] == tlbl_pkg::AGE_MAX);
        end
    end

    assign hit_oh  = lowest_one(match);
    assign any_hit = |match;

    // Mux out frame and age of the hit entry.
    always_comb
    begin
        hit_frame = '0;
        hit_age   = '0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (hit_oh[i])
            begin
                hit_frame = hit_frame | frame_reg[i];
                hit_age   = hit_age | age_reg[i];
            end
        end
    end

    // Oldest entry: lowest index among the smallest age level present.
    always_comb
    begin
        if (|age0_vec)
            min_oh = lowest_one(age0_vec);
        else if (|age1_vec)
            min_oh = lowest_one(age1_vec);
        else if (|age2_vec)
            min_oh = lowest_one(age2_vec);
        else
            min_oh = lowest_one(age_max_vec);
    end

    assign ins_oh = (|(~valid_reg)) ? lowest_one(~valid_reg) : min_oh;
    assign wr_en  = (go && is_insert) ? ins_oh : '0;

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < NUM_ENTRIES; i++)
            age_next[i] = age_reg[i];

        if (go && is_insert)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                if (ins_oh[i])
                begin
                    valid_next[i] = 1'b1;
                    age_next[i]   = tlbl_pkg::AGE_MAX;
                end
                else if (valid_reg[i] && age_nz_vec[i])
                begin
                    age_next[i] = age_reg[i] - 2'd1;
                end
            end
        end
        else if (go && any_hit && (hit_age != tlbl_pkg::AGE_MAX))
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                if (hit_oh[i])
                    age_next[i] = tlbl_pkg::AGE_MAX;
                else if (age_nz_vec[i])
                    age_next[i] = age_reg[i] - 2'd1;
            end
        end
    end

    always_comb
    begin
        rsp.hit           = !is_insert && any_hit;
        rsp.found_address = rsp.hit ? hit_frame : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < NUM_ENTRIES; i++)
                age_reg[i] <= tlbl_pkg::AGE_ZERO;
        end
        else
        begin
            valid_reg <= valid_next;
            for (int i = 0; i < NUM_ENTRIES; i++)
                age_reg[i] <= age_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (wr_en[i])
            begin
                tag_reg[i]   <= tag_in;
                frame_reg[i] <= req.frame_address;
            end
        end
    end

    `TLBL_ASSERT_SAME(a_free_entry_age_zero, clk, rst_n, 1'b1, ((age_nz_vec & ~valid_reg) == '0))
    `TLBL_ASSERT_SAME(a_insert_one_slot, clk, rst_n, go && is_insert, $onehot(ins_oh))
    `TLBL_ASSERT_NEXT(a_insert_sets_valid, clk, rst_n, go && is_insert,
        ((valid_reg & $past(ins_oh)) == $past(ins_oh)))
    `TLBL_ASSERT_NEXT(a_hit_becomes_youngest, clk, rst_n, go && !is_insert && any_hit,
        ((age_max_vec & $past(hit_oh)) == $past(hit_oh)))

endmodule

`default_nettype wire

FILE: sv/tlb_lookup_with_lru_counters.sv
// ---------------------------------------------------------------------------
// tlb_lookup_with_lru_counters
// Fully associative translation buffer with per-entry age counters.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one item: a lookup
//   (func = lookup) or an insert of a new translation (func = insert).
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one item per
//   request: hit and the stored frame on a lookup hit, zeros otherwise.
//   An item is taken into the input register, resolved against all entries
//   (parallel tag compare, victim pick, age update) and lands in the result
//   register, which drives rsp_valid; it moves on once the result
//   register is free or its item is leaving. Throughput is one item per
//   cycle while the receiver does not stall; the entry store is updated in
//   the same edge that loads the result, so the next item already sees it.
//   When the receiver stalls, the result register holds its item and the
//   input register fills; req_stall rises only while both are occupied
//   and the result cannot leave.
//   Reset clears all valid bits and ages and empties both registers; tag
//   and frame contents are only read behind a set valid bit.
// ---------------------------------------------------------------------------
`default_nettype none

module tlb_lookup_with_lru_counters #(
    parameter int NUM_ENTRIES = 4
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire tlbl_pkg::req_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output tlbl_pkg::rsp_t rsp
);

    logic           in_valid_reg;
    logic           in_valid_next;
    tlbl_pkg::req_t in_req_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    tlbl_pkg::rsp_t out_rsp_reg;
    tlbl_pkg::rsp_t lookup_rsp;
    logic           accept;
    logic           advance;

    // Move the held item forward whenever the result slot is free or leaving.
    assign advance   = in_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    tlbl_entries #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_entries (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (advance),
        .req   (in_req_reg),
        .rsp   (lookup_rsp)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!rsp_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on handshake, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
            in_req_reg <= req;
        if (advance)
            out_rsp_reg <= lookup_rsp;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_rsp_reg;

endmodule

`default_nettype wire
